FILE: hdl/assert_macros.svh
// Assertion helpers included by triangle_unit_normal_top.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, masked while rst_n is low.
`define TUN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication form: the consequent is checked in the same cycle as the antecedent.
`define TUN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hdl/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// Widths and transaction types for the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tun_pkg;

  localparam int CW  = 16;          // corner coordinate width
  localparam int FB  = 14;          // fraction bits of the normal
  localparam int OW  = 16;          // normal field width
  localparam int EW  = CW + 1;      // edge vector component
  localparam int PW  = 2 * EW;      // edge product
  localparam int NW  = PW + 1;      // cross product component, signed
  localparam int MW  = NW - 1;      // cross product magnitude
  localparam int HW  = (MW + 1) / 2; // low half of a magnitude
  localparam int HIW = MW - HW;     // high half of a magnitude
  localparam int SW  = 2 * MW + 2;  // sum of squares
  localparam int RW  = SW / 2;      // length (square root)
  localparam int RMW = RW + 3;      // square root remainder
  localparam int DRW = RW + 1;      // divider partial remainder
  localparam int QW  = FB + 1;      // quotient magnitude

  localparam int FRONT = 6;                       // edge .. sum stages
  localparam int SQ0   = FRONT;                   // first root stage
  localparam int DV0   = SQ0 + RW;                // first divide stage
  localparam int OST   = DV0 + QW;                // output register stage
  localparam int NSTG  = OST + 1;

  typedef struct packed {
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] first_z;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;
    logic signed [CW-1:0] second_z;
    logic signed [CW-1:0] third_x;
    logic signed [CW-1:0] third_y;
    logic signed [CW-1:0] third_z;
  } tri_in_t;

  typedef struct packed {
    logic signed [OW-1:0] normal_x;
    logic signed [OW-1:0] normal_y;
    logic signed [OW-1:0] normal_z;
    logic                 degenerate;
  } tri_out_t;

  typedef logic signed [EW-1:0] edge_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [NW-1:0] cross_t;

  typedef struct packed {
    logic [2:0][MW-1:0] mag;
    logic [2:0]         neg;
  } side_t;

endpackage

FILE: hdl/triangle_unit_normal_top.sv
// Pipeline: tun_pkg::NSTG register stages (57 stages at 16-bit corners).
// Throughput: one triangle per cycle while out_ready keeps the output moving; the square root
// retires one length bit per stage and each divider one quotient bit per stage.
// Stages advance independently, so bubbles close up behind a stalled output.
// Reset (rst_n low, synchronous) clears every stage valid; data registers are not reset.
// ----------------------------------------------------------------------------
// triangle_unit_normal_top
// Unit face normal: edge vectors, cross product, floor square root of the
// squared length, and three restoring dividers giving signed Q1.FB results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module triangle_unit_normal_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tun_pkg::tri_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tun_pkg::tri_out_t out_data
);

  localparam int NSTG = tun_pkg::NSTG;
  localparam int RW   = tun_pkg::RW;
  localparam int QW   = tun_pkg::QW;
  localparam int SQ0  = tun_pkg::SQ0;
  localparam int DV0  = tun_pkg::DV0;
  localparam int OST  = tun_pkg::OST;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] adv;

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[OST];

  // ---------------- front: edges, products, cross product, squares, sum
  tun_pkg::edge_t                   e1_r [3];
  tun_pkg::edge_t                   e2_r [3];
  tun_pkg::prod_t                   p_r  [6];
  logic [2:0][2*tun_pkg::HW-1:0]    ll_r;
  logic [2:0][tun_pkg::MW-1:0]      lh_r;
  logic [2:0][2*tun_pkg::HIW-1:0]   hh_r;
  logic [2:0][tun_pkg::SW-1:0]      sqr_r;
  logic [tun_pkg::SW-1:0]           sum_r;
  tun_pkg::side_t                   side_r [2:OST-1];
  tun_pkg::cross_t                  nx, ny, nz;

  always_comb begin
    nx = tun_pkg::cross_t'(p_r[0]) - tun_pkg::cross_t'(p_r[1]);
    ny = tun_pkg::cross_t'(p_r[2]) - tun_pkg::cross_t'(p_r[3]);
    nz = tun_pkg::cross_t'(p_r[4]) - tun_pkg::cross_t'(p_r[5]);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      e1_r[0] <= tun_pkg::edge_t'(in_data.first_x) - tun_pkg::edge_t'(in_data.second_x);
      e1_r[1] <= tun_pkg::edge_t'(in_data.first_y) - tun_pkg::edge_t'(in_data.second_y);
      e1_r[2] <= tun_pkg::edge_t'(in_data.first_z) - tun_pkg::edge_t'(in_data.second_z);
      e2_r[0] <= tun_pkg::edge_t'(in_data.second_x) - tun_pkg::edge_t'(in_data.third_x);
      e2_r[1] <= tun_pkg::edge_t'(in_data.second_y) - tun_pkg::edge_t'(in_data.third_y);
      e2_r[2] <= tun_pkg::edge_t'(in_data.second_z) - tun_pkg::edge_t'(in_data.third_z);
    end
    if (adv[1]) begin
      p_r[0] <= tun_pkg::prod_t'(e1_r[1]) * tun_pkg::prod_t'(e2_r[2]);
      p_r[1] <= tun_pkg::prod_t'(e1_r[2]) * tun_pkg::prod_t'(e2_r[1]);
      p_r[2] <= tun_pkg::prod_t'(e1_r[2]) * tun_pkg::prod_t'(e2_r[0]);
      p_r[3] <= tun_pkg::prod_t'(e1_r[0]) * tun_pkg::prod_t'(e2_r[2]);
      p_r[4] <= tun_pkg::prod_t'(e1_r[0]) * tun_pkg::prod_t'(e2_r[1]);
      p_r[5] <= tun_pkg::prod_t'(e1_r[1]) * tun_pkg::prod_t'(e2_r[0]);
    end
    if (adv[2]) begin
      side_r[2].neg <= {nz[tun_pkg::NW-1], ny[tun_pkg::NW-1], nx[tun_pkg::NW-1]};
      side_r[2].mag[0] <= tun_pkg::MW'(nx[tun_pkg::NW-1] ? -nx : nx);
      side_r[2].mag[1] <= tun_pkg::MW'(ny[tun_pkg::NW-1] ? -ny : ny);
      side_r[2].mag[2] <= tun_pkg::MW'(nz[tun_pkg::NW-1] ? -nz : nz);
    end
    // Split each square into three narrow partial products.
    if (adv[3]) begin
      for (int i = 0; i < 3; i++) begin
        ll_r[i] <= (2*tun_pkg::HW)'(side_r[2].mag[i][tun_pkg::HW-1:0])
                 * (2*tun_pkg::HW)'(side_r[2].mag[i][tun_pkg::HW-1:0]);
        lh_r[i] <= tun_pkg::MW'(side_r[2].mag[i][tun_pkg::HW-1:0])
                 * tun_pkg::MW'(side_r[2].mag[i][tun_pkg::MW-1:tun_pkg::HW]);
        hh_r[i] <= (2*tun_pkg::HIW)'(side_r[2].mag[i][tun_pkg::MW-1:tun_pkg::HW])
                 * (2*tun_pkg::HIW)'(side_r[2].mag[i][tun_pkg::MW-1:tun_pkg::HW]);
      end
    end
    if (adv[4]) begin
      for (int i = 0; i < 3; i++) begin
        sqr_r[i] <= (tun_pkg::SW'(hh_r[i]) << (2 * tun_pkg::HW))
                  + (tun_pkg::SW'(lh_r[i]) << (tun_pkg::HW + 1))
                  + tun_pkg::SW'(ll_r[i]);
      end
    end
    if (adv[5]) begin
      sum_r <= sqr_r[0] + sqr_r[1] + sqr_r[2];
    end
  end

  // Magnitudes and signs ride along with the item.
  for (genvar s = 3; s < OST; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv[s]) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  // ---------------- square root: one root bit per stage
  logic [tun_pkg::RMW-1:0] sq_rem_r  [RW];
  logic [RW-1:0]           sq_root_r [RW];
  logic [tun_pkg::SW-1:0]  sq_rad_r  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [tun_pkg::RMW-1:0] rem_in, cur, trial;
    logic [RW-1:0]           root_in;
    logic [tun_pkg::SW-1:0]  rad_in;
    logic                    ge;

    always_comb begin
      if (k == 0) begin
        rem_in  = '0;
        root_in = '0;
        rad_in  = sum_r;
      end else begin
        rem_in  = sq_rem_r[(k == 0) ? 0 : k-1];
        root_in = sq_root_r[(k == 0) ? 0 : k-1];
        rad_in  = sq_rad_r[(k == 0) ? 0 : k-1];
      end
      cur   = {rem_in[tun_pkg::RMW-3:0], rad_in[tun_pkg::SW-1 -: 2]};
      trial = {1'b0, root_in, 2'b01};
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (adv[SQ0+k]) begin
        sq_rem_r[k]  <= ge ? cur - trial : cur;
        sq_root_r[k] <= {root_in[RW-2:0], ge};
        sq_rad_r[k]  <= rad_in << 2;
      end
    end
  end

  // ---------------- dividers: one quotient bit per stage, three lanes
  logic [RW-1:0]                dv_len_r [QW];
  logic [2:0][tun_pkg::DRW-1:0] dv_rem_r [QW];
  logic [2:0][QW-1:0]           dv_q_r   [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [RW-1:0]                len_in;
    logic [2:0][tun_pkg::DRW-1:0] rs, rem_nxt;
    logic [2:0][QW-1:0]           q_in, q_nxt;

    always_comb begin
      if (j == 0) begin
        len_in = sq_root_r[RW-1];
        q_in   = '0;
        for (int i = 0; i < 3; i++) begin
          rs[i] = tun_pkg::DRW'(side_r[DV0-1].mag[i]);
        end
      end else begin
        len_in = dv_len_r[(j == 0) ? 0 : j-1];
        q_in   = dv_q_r[(j == 0) ? 0 : j-1];
        for (int i = 0; i < 3; i++) begin
          rs[i] = {dv_rem_r[(j == 0) ? 0 : j-1][i][tun_pkg::DRW-2:0], 1'b0};
        end
      end
      for (int i = 0; i < 3; i++) begin
        if (rs[i] >= tun_pkg::DRW'(len_in)) begin
          rem_nxt[i] = rs[i] - tun_pkg::DRW'(len_in);
          q_nxt[i]   = {q_in[i][QW-2:0], 1'b1};
        end else begin
          rem_nxt[i] = rs[i];
          q_nxt[i]   = {q_in[i][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv[DV0+j]) begin
        dv_len_r[j] <= len_in;
        dv_rem_r[j] <= rem_nxt;
        dv_q_r[j]   <= q_nxt;
      end
    end
  end

  // ---------------- output register: apply sign, wrap, zero on degenerate
  tun_pkg::tri_out_t          out_nxt;
  tun_pkg::tri_out_t          out_r;
  logic [2:0][QW+tun_pkg::OW-1:0] sgn;
  logic                       deg;

  always_comb begin
    deg = (dv_len_r[QW-1] == '0);
    for (int i = 0; i < 3; i++) begin
      sgn[i] = {{tun_pkg::OW{1'b0}}, dv_q_r[QW-1][i]};
      if (side_r[OST-1].neg[i]) begin
        sgn[i] = -sgn[i];
      end
      if (deg) begin
        sgn[i] = '0;
      end
    end
    out_nxt.normal_x   = sgn[0][tun_pkg::OW-1:0];
    out_nxt.normal_y   = sgn[1][tun_pkg::OW-1:0];
    out_nxt.normal_z   = sgn[2][tun_pkg::OW-1:0];
    out_nxt.degenerate = deg;
  end

  always_ff @(posedge clk) begin
    if (adv[OST]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

  // ---------------- checks
  `TUN_ASSERT_IMP(a_deg_zero, out_valid && out_data.degenerate,
    out_data.normal_x == 0 && out_data.normal_y == 0 && out_data.normal_z == 0,
    "degenerate result with nonzero normal")
  `TUN_ASSERT_IMP(a_div_rem, vld_r[OST-1] && dv_len_r[QW-1] != '0,
    dv_rem_r[QW-1][0] < tun_pkg::DRW'(dv_len_r[QW-1])
    && dv_rem_r[QW-1][1] < tun_pkg::DRW'(dv_len_r[QW-1])
    && dv_rem_r[QW-1][2] < tun_pkg::DRW'(dv_len_r[QW-1]),
    "divider remainder not below length")
  `TUN_ASSERT_IMP(a_bubble_ready, !vld_r[0], in_ready,
    "input blocked while first stage empty")
  `TUN_ASSERT(a_sqrt_rem,
    !vld_r[SQ0+RW-1] || sq_rem_r[RW-1] <= tun_pkg::RMW'({sq_root_r[RW-1], 1'b0}),
    "square root remainder exceeds twice the root")

endmodule
